### rtl/ate_pkg.sv
// shared types, constants and character codes of the expression tokenizer
package ate_pkg;

  localparam int unsigned MantissaBitsDef  = 32;
  localparam int unsigned MaxFracDigitsDef = 9;

  localparam int unsigned MantOutW  = 32;
  localparam int unsigned FracW     = 4;
  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic TokNumber = 1'b0;
  localparam logic TokOper   = 1'b1;

  typedef enum logic [2:0] {
    OP_PLUS  = 3'd0,
    OP_MINUS = 3'd1,
    OP_TIMES = 3'd2,
    OP_DIV   = 3'd3,
    OP_OPEN  = 3'd4,
    OP_CLOSE = 3'd5
  } op_e;

  // tokens caused by one character: optional number, then optional operator
  typedef struct packed {
    logic                num_valid;
    logic                op_valid;
    op_e                 op_code;
    logic [MantOutW-1:0] mantissa;
    logic [FracW-1:0]    frac_digits;
    logic                overflow;
  } tok_entry_t;

endpackage

### rtl/arith_expression_tokenizer.sv
// top level of the arithmetic expression tokenizer
// Takes one ASCII character per transaction (plus an end-of-expression flag) and
// emits number and operator tokens. A number is a decimal mantissa plus a count
// of kept fraction digits; value = mantissa / 10^frac_digits. The input side
// accepts one character every cycle while the queue is not full; the number
// accumulator is a register updated with a shift-and-add multiply by ten. Tokens
// leave through a registered output at one per cycle while out_ready_i is high,
// each via the queue and then the output register. A character that closes a
// number and is an operator yields two tokens from one entry; a four-entry queue
// between classifier and output stage absorbs this; in_ready_o drops only when it is full.
module arith_expression_tokenizer import ate_pkg::*; #(
  parameter int unsigned MANTISSA_BITS   = MantissaBitsDef,
  parameter int unsigned MAX_FRAC_DIGITS = MaxFracDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // character channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          ch_i,
  input  logic                end_of_expression_i,
  // token channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                token_kind_o,
  output logic [2:0]          op_code_o,
  output logic [MantOutW-1:0] mantissa_o,
  output logic [FracW-1:0]    frac_digits_o,
  output logic                overflow_o,
  output logic                last_of_run_o
);

  // one queue entry holds every token a single character causes
  logic       push, pop, fifo_empty, fifo_full;
  tok_entry_t entry, head;

  // classification, number state and token formation
  ate_front #(
    .MANTISSA_BITS   (MANTISSA_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .ch_i                (ch_i),
    .end_of_expression_i (end_of_expression_i),
    .fifo_full_i         (fifo_full),
    .push_o              (push),
    .entry_o             (entry)
  );

  // decouples the character stream from output stalls
  ate_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // number first, then operator, one token per output transaction
  ate_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (fifo_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .op_code_o     (op_code_o),
    .mantissa_o    (mantissa_o),
    .frac_digits_o (frac_digits_o),
    .overflow_o    (overflow_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### rtl/ate_front.sv
// front end: character classification and number accumulation
module ate_front import ate_pkg::*; #(
  parameter int unsigned MANTISSA_BITS   = MantissaBitsDef,
  parameter int unsigned MAX_FRAC_DIGITS = MaxFracDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_expression_i,
  input  logic       fifo_full_i,
  output logic       push_o,
  output tok_entry_t entry_o
);

  localparam int unsigned W = MANTISSA_BITS;

  logic             in_number_q, in_number_d;
  logic             in_fraction_q, in_fraction_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic             sat_q, sat_d;

  logic             accept;
  logic             is_decimal, is_mark, is_other;
  logic [3:0]       digit;
  logic [7:0]       digit_full;
  logic [W+3:0]     acc_ext, sum;
  logic             sat_step, do_acc;
  logic [W-1:0]     acc_step;
  logic             in_number_n, in_fraction_n, sat_n;
  logic [W-1:0]     acc_n;
  logic [FracW-1:0] frac_n;
  logic             num_emit, op_valid;
  op_e              op_code;
  logic [W-1:0]     num_acc;
  logic [W+31:0]    mant_ext;

  assign in_ready_o = ~fifo_full_i;
  assign accept     = in_valid_i & ~fifo_full_i;

  assign is_decimal = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_mark    = (ch_i == ChDot) || (ch_i == ChComma);
  assign is_other   = ~is_decimal & ~is_mark;
  assign digit_full = ch_i - ChZero;
  assign digit      = digit_full[3:0];

  // acc * 10 + digit, saturating at the all-ones mantissa
  assign acc_ext  = {4'b0000, acc_q};
  assign sum      = (acc_ext << 3) + (acc_ext << 1) + {{W{1'b0}}, digit};
  assign sat_step = |sum[W+3:W];
  assign acc_step = sat_step ? {W{1'b1}} : sum[W-1:0];
  assign do_acc   = is_decimal && (!in_fraction_q || (frac_q < FracW'(MAX_FRAC_DIGITS)));

  always_comb begin
    op_valid = 1'b1;
    op_code  = OP_PLUS;
    unique case (ch_i)
      ChPlus:  op_code = OP_PLUS;
      ChMinus: op_code = OP_MINUS;
      ChStar:  op_code = OP_TIMES;
      ChSlash: op_code = OP_DIV;
      ChOpen:  op_code = OP_OPEN;
      ChClose: op_code = OP_CLOSE;
      default: op_valid = 1'b0;
    endcase
  end

  always_comb begin
    if (is_other) begin
      in_number_n   = 1'b0;
      in_fraction_n = 1'b0;
      acc_n         = '0;
      frac_n        = '0;
      sat_n         = 1'b0;
    end else begin
      in_number_n   = 1'b1;
      in_fraction_n = in_fraction_q | is_mark;
      acc_n         = do_acc ? acc_step : acc_q;
      frac_n        = (do_acc && in_fraction_q) ? frac_q + 1'b1 : frac_q;
      sat_n         = sat_q | (do_acc & sat_step);
    end
  end

  // an other byte closes the running number; a digit or mark closes it at expression end
  assign num_emit = is_other ? in_number_q : end_of_expression_i;
  assign num_acc  = is_other ? acc_q : acc_n;
  assign mant_ext = {32'b0, num_acc};

  always_comb begin
    entry_o.num_valid   = num_emit;
    entry_o.op_valid    = is_other & op_valid;
    entry_o.op_code     = op_code;
    entry_o.mantissa    = mant_ext[MantOutW-1:0];
    entry_o.frac_digits = is_other ? frac_q : frac_n;
    entry_o.overflow    = is_other ? sat_q : sat_n;
  end

  assign push_o = accept & (num_emit | (is_other & op_valid));

  always_comb begin
    if (end_of_expression_i) begin
      in_number_d   = 1'b0;
      in_fraction_d = 1'b0;
      acc_d         = '0;
      frac_d        = '0;
      sat_d         = 1'b0;
    end else begin
      in_number_d   = in_number_n;
      in_fraction_d = in_fraction_n;
      acc_d         = acc_n;
      frac_d        = frac_n;
      sat_d         = sat_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q   <= 1'b0;
      in_fraction_q <= 1'b0;
      acc_q         <= '0;
      frac_q        <= '0;
      sat_q         <= 1'b0;
    end else if (accept) begin
      in_number_q   <= in_number_d;
      in_fraction_q <= in_fraction_d;
      acc_q         <= acc_d;
      frac_q        <= frac_d;
      sat_q         <= sat_d;
    end
  end

  a_frac_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= FracW'(MAX_FRAC_DIGITS))
    else $error("fraction count past limit");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_number_q |-> (acc_q == '0 && frac_q == '0 && !in_fraction_q && !sat_q))
    else $error("number state not cleared outside a number");

endmodule

### rtl/ate_fifo.sv
// short token queue between front end and back end
module ate_fifo import ate_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tok_entry_t entry_i,
  input  logic       pop_i,
  output tok_entry_t head_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  tok_entry_t        mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(FifoDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("queue count out of range");

endmodule

### rtl/ate_back.sv
// back end: expands queued entries into tokens on the output register
module ate_back import ate_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  input  tok_entry_t          head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                token_kind_o,
  output logic [2:0]          op_code_o,
  output logic [MantOutW-1:0] mantissa_o,
  output logic [FracW-1:0]    frac_digits_o,
  output logic                overflow_o,
  output logic                last_of_run_o
);

  logic                out_valid_q, out_valid_d;
  logic                num_done_q, num_done_d;
  logic                kind_q, kind_d;
  logic [2:0]          op_q, op_d;
  logic [MantOutW-1:0] mant_q, mant_d;
  logic [FracW-1:0]    frac_q, frac_d;
  logic                ovf_q, ovf_d;
  logic                last_q, last_d;
  logic                load, send_num;

  assign load     = (!out_valid_q || out_ready_i) && !fifo_empty_i;
  assign send_num = head_i.num_valid && !num_done_q;

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    num_done_d  = num_done_q;
    pop_o       = 1'b0;
    kind_d      = kind_q;
    op_d        = op_q;
    mant_d      = mant_q;
    frac_d      = frac_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (send_num) begin
        kind_d     = TokNumber;
        op_d       = OP_PLUS;
        mant_d     = head_i.mantissa;
        frac_d     = head_i.frac_digits;
        ovf_d      = head_i.overflow;
        last_d     = ~head_i.op_valid;
        num_done_d = head_i.op_valid;
        pop_o      = ~head_i.op_valid;
      end else begin
        kind_d     = TokOper;
        op_d       = head_i.op_code;
        mant_d     = '0;
        frac_d     = '0;
        ovf_d      = 1'b0;
        last_d     = 1'b1;
        num_done_d = 1'b0;
        pop_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      num_done_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      num_done_q  <= num_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    op_q   <= op_d;
    mant_q <= mant_d;
    frac_q <= frac_d;
    ovf_q  <= ovf_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign op_code_o     = op_q;
  assign mantissa_o    = mant_q;
  assign frac_digits_o = frac_q;
  assign overflow_o    = ovf_q;
  assign last_of_run_o = last_q;

  a_half_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_done_q |-> (!fifo_empty_i && head_i.num_valid && head_i.op_valid))
    else $error("split entry lost its operator half");

  a_oper_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == TokOper) |-> (mant_q == '0 && frac_q == '0 && !ovf_q && last_q))
    else $error("operator token carries number fields");

endmodule
